[rtl/core/integral_image_builder_unit_defines.svh]
// Assertion macros for the integral image builder.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef INTEGRAL_IMAGE_BUILDER_UNIT_DEFINES_SVH
`define INTEGRAL_IMAGE_BUILDER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define IIB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define IIB_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `IIB_ASSERT(label, clk, rst_n, !(cond), msg)

`else

`define IIB_ASSERT(label, clk, rst_n, prop, msg)

`define IIB_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

[rtl/core/iib_pkg.sv]
// Shared constants, types and helpers of the integral image builder.
// No dependencies.
package iib_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 2;
  localparam int PIX_W     = 24;
  localparam int GRAY_W    = 8;
  localparam int GSUM_W    = GRAY_W + 5;
  localparam int RUN_W     = $clog2(MAX_WIDTH * 255 + 1);
  localparam int STORE_W   = 27;
  localparam int AREA_W    = 26;

  localparam int FIFO_DEPTH = 3;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(320);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(200);

  typedef struct packed {
    logic [COL_W-1:0]   col;
    logic               row_nz;
    logic [RUN_W-1:0]   run;
    logic               row_end;
    logic               frame_end;
    logic               fwd;
    logic [STORE_W-1:0] fwd_area;
  } stage_t;

  typedef struct packed {
    logic [AREA_W-1:0] area;
    logic              row_end;
    logic              frame_end;
  } result_t;

  // (11R + 16G + 5B) / 32
  function automatic logic [GRAY_W-1:0] gray_of(input logic [PIX_W-1:0] color);
    logic [GSUM_W-1:0] r;
    logic [GSUM_W-1:0] g;
    logic [GSUM_W-1:0] b;
    logic [GSUM_W-1:0] s;
    r = GSUM_W'(color[23:16]);
    g = GSUM_W'(color[15:8]);
    b = GSUM_W'(color[7:0]);
    s = (r << 3) + (r << 1) + r + (g << 4) + (b << 2) + b;
    return s[GSUM_W-1:5];
  endfunction

endpackage

[rtl/core/iib_ram.sv]
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module iib_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/integral_image_builder_unit.sv]
// Integral image builder top level: gray conversion, row sum and line store.
// Depends on iib_pkg, iib_ram and integral_image_builder_unit_defines.svh.
//
// Takes one RGB pixel per clock in raster order, unless stalled, and returns
// one summed-area value per pixel, with row and frame end flags. Sustained
// rate is one pixel per cycle when neither side stalls. The result of a request
// taken at one clock edge is offered from the next edge on: the accepting
// edge also reads the line store, and the next one adds the row above, writes
// back and queues the value. Results wait in a three-entry queue, so input
// stalls only once the queue and the in-flight pixel fill it. The line store
// needs no clearing after reset: the first row of a frame ignores it. The user
// must write width and height only while idle; the block does not enforce it.
module integral_image_builder_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [iib_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [iib_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [iib_pkg::PIX_W-1:0]      pixel_color_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [iib_pkg::AREA_W-1:0]     area_sum_o,
  output logic                           row_end_o,
  output logic                           frame_end_o
);

`include "integral_image_builder_unit_defines.svh"

  logic [iib_pkg::CFG_W-1:0]   width_q;
  logic [iib_pkg::CFG_W-1:0]   height_q;
  logic [iib_pkg::COL_W-1:0]   w_last;
  logic [iib_pkg::ROW_W-1:0]   h_last;

  logic [iib_pkg::COL_W-1:0]   col_q, col_d;
  logic [iib_pkg::ROW_W-1:0]   row_q, row_d;
  logic [iib_pkg::RUN_W-1:0]   run_q, run_d;
  logic [iib_pkg::GRAY_W-1:0]  gray;
  logic                        row_last;
  logic                        frame_last;
  logic                        acc;

  logic                        s1_valid_q;
  iib_pkg::stage_t             s1_q, s1_d;
  logic [iib_pkg::STORE_W-1:0] rdata;
  logic [iib_pkg::STORE_W-1:0] above;
  logic [iib_pkg::STORE_W-1:0] area;

  iib_pkg::result_t            fifo_q [iib_pkg::FIFO_DEPTH];
  logic [iib_pkg::PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [iib_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic                        push;
  logic                        pop;
  iib_pkg::result_t            head;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= iib_pkg::WIDTH_RST;
      height_q <= iib_pkg::HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        iib_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        iib_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // clamped last column and row
  always_comb begin
    if (width_q == '0) begin
      w_last = '0;
    end else if (32'(width_q) > iib_pkg::MAX_WIDTH) begin
      w_last = iib_pkg::COL_W'(iib_pkg::MAX_WIDTH - 1);
    end else begin
      w_last = iib_pkg::COL_W'(width_q - 1'b1);
    end
    if (height_q == '0) begin
      h_last = '0;
    end else if (32'(height_q) > iib_pkg::MAX_HEIGHT) begin
      h_last = iib_pkg::ROW_W'(iib_pkg::MAX_HEIGHT - 1);
    end else begin
      h_last = iib_pkg::ROW_W'(height_q - 1'b1);
    end
  end

  assign in_stall_o = s1_valid_q ? (cnt_q >= iib_pkg::CNT_W'(iib_pkg::FIFO_DEPTH - 1))
                                 : (cnt_q >= iib_pkg::CNT_W'(iib_pkg::FIFO_DEPTH));
  assign acc        = in_valid_i && !in_stall_o;

  assign gray       = iib_pkg::gray_of(pixel_color_i);
  assign row_last   = col_q >= w_last;
  assign frame_last = row_last && (row_q >= h_last);

  // stage 0: counters, row sum, line store read
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    run_d = ((col_q == '0) ? '0 : run_q) + iib_pkg::RUN_W'(gray);
    if (row_last) begin
      col_d = '0;
      row_d = frame_last ? '0 : row_q + 1'b1;
    end else begin
      col_d = col_q + 1'b1;
    end

    s1_d.col       = col_q;
    s1_d.row_nz    = row_q != '0;
    s1_d.run       = run_d;
    s1_d.row_end   = row_last;
    s1_d.frame_end = frame_last;
    // same entry written this cycle by the pixel ahead
    s1_d.fwd       = s1_valid_q && (s1_q.col == col_q);
    s1_d.fwd_area  = area;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      run_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= acc;
      if (acc) begin
        col_q <= col_d;
        row_q <= row_d;
        run_q <= run_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q <= s1_d;
    end
  end

  iib_ram #(
    .WIDTH (iib_pkg::STORE_W),
    .DEPTH (iib_pkg::MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_q.col),
    .wdata_i (area),
    .raddr_i (col_q),
    .rdata_o (rdata)
  );

  // stage 1: add the row above, write back
  assign above = s1_q.row_nz ? (s1_q.fwd ? s1_q.fwd_area : rdata) : '0;
  assign area  = above + iib_pkg::STORE_W'(s1_q.run);

  // result queue
  assign push = s1_valid_q;
  assign pop  = out_valid_o && !out_stall_i;

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == iib_pkg::PTR_W'(iib_pkg::FIFO_DEPTH - 1)) ? '0
                                                                         : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == iib_pkg::PTR_W'(iib_pkg::FIFO_DEPTH - 1)) ? '0
                                                                         : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q].area      <= area[iib_pkg::AREA_W-1:0];
      fifo_q[wr_ptr_q].row_end   <= s1_q.row_end;
      fifo_q[wr_ptr_q].frame_end <= s1_q.frame_end;
    end
  end

  assign head        = fifo_q[rd_ptr_q];
  assign out_valid_o = cnt_q != '0;
  assign area_sum_o  = head.area;
  assign row_end_o   = head.row_end;
  assign frame_end_o = head.frame_end;

  `IIB_ASSERT(a_queue_room, clk_i, rst_ni,
              s1_valid_q |-> cnt_q < iib_pkg::CNT_W'(iib_pkg::FIFO_DEPTH),
              "result queue full while a pixel is in flight")
  `IIB_ASSERT(a_frame_wrap, clk_i, rst_ni,
              (acc && frame_last) |=> (col_q == '0 && row_q == '0),
              "counters did not wrap at frame end")
  `IIB_ASSERT(a_row_restart, clk_i, rst_ni,
              (acc && col_q == '0) |=> run_q == iib_pkg::RUN_W'($past(gray)),
              "row sum did not restart at first column")
  `IIB_ASSERT_NEVER(a_frame_flag, clk_i, rst_ni,
                    out_valid_o && frame_end_o && !row_end_o,
                    "frame end without row end")

endmodule

[bench/tb_integral_image_builder_unit.sv]
// Testbench for integral_image_builder_unit: raster pixels in, summed-area values out.
// Needs iib_pkg and the block's RTL. The bench predicts every result itself and
// checks each one in order while both handshakes idle and stall at random.
`timescale 1ns / 100ps

module tb_integral_image_builder_unit;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned RANDOM_TARGET = 1800;
  localparam int unsigned TAIL_CYCLES   = 8;

  localparam logic [iib_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = iib_pkg::CFG_IDX_W'(2);
  localparam logic [iib_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = iib_pkg::CFG_IDX_W'(3);

  logic                          clk_i;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_we_i      = 1'b0;
  logic [iib_pkg::CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [iib_pkg::CFG_W-1:0]     cfg_wdata_i   = '0;
  logic                          in_valid_i    = 1'b0;
  logic                          in_stall_o;
  logic [iib_pkg::PIX_W-1:0]     pixel_color_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i   = 1'b0;
  logic [iib_pkg::AREA_W-1:0]    area_sum_o;
  logic                          row_end_o;
  logic                          frame_end_o;

  integral_image_builder_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_color_i (pixel_color_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .area_sum_o    (area_sum_o),
    .row_end_o     (row_end_o),
    .frame_end_o   (frame_end_o)
  );

  // shadow of the block's geometry, line store and counters
  logic [iib_pkg::CFG_W-1:0] width_reg  = iib_pkg::WIDTH_RST;
  logic [iib_pkg::CFG_W-1:0] height_reg = iib_pkg::HEIGHT_RST;
  int unsigned               line_sums [iib_pkg::MAX_WIDTH];
  bit                        line_written [iib_pkg::MAX_WIDTH];
  int unsigned               row_sum = 0;
  int unsigned               col_at  = 0;
  int unsigned               row_at  = 0;

  iib_pkg::result_t pending_sums [$];
  int unsigned      mismatch_count = 0;
  int unsigned      pixels_sent    = 0;
  bit               quiet          = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned dim_clamp(input logic [iib_pkg::CFG_W-1:0] v,
                                            input int unsigned max);
    if (v == 0) return 1;
    if (v > max) return max;
    return v;
  endfunction

  function automatic iib_pkg::result_t integrate_pixel(input logic [iib_pkg::PIX_W-1:0] color);
    iib_pkg::result_t res;
    int unsigned      w;
    int unsigned      h;
    int unsigned      gray;
    int unsigned      above;
    int unsigned      total;
    bit               last_col;
    bit               last_row;
    w = dim_clamp(width_reg, iib_pkg::MAX_WIDTH);
    h = dim_clamp(height_reg, iib_pkg::MAX_HEIGHT);
    gray = (11 * int'(color[23:16]) + 16 * int'(color[15:8]) + 5 * int'(color[7:0])) >> 5;
    last_col = (col_at >= w - 1);
    last_row = last_col && (row_at >= h - 1);
    if (col_at == 0) row_sum = 0;
    row_sum += gray;
    above = (row_at != 0) ? line_sums[col_at] : 0;
    total = (above + row_sum) & 32'h7FF_FFFF;
    line_sums[col_at]    = total;
    line_written[col_at] = 1'b1;
    res.area      = iib_pkg::AREA_W'(total);
    res.row_end   = last_col;
    res.frame_end = last_row;
    if (last_col) begin
      col_at = 0;
      row_at = last_row ? 0 : row_at + 1;
    end else begin
      col_at++;
    end
    return res;
  endfunction

  // a wider row must never read a line store entry that was never written
  function automatic bit width_ok(input logic [iib_pkg::CFG_W-1:0] v);
    int unsigned w;
    w = dim_clamp(v, iib_pkg::MAX_WIDTH);
    if (row_at == 0) return 1'b1;
    for (int unsigned c = 0; c < w; c++) begin
      if (!line_written[c]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [iib_pkg::PIX_W-1:0] random_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return iib_pkg::PIX_W'($urandom);
    endcase
  endfunction

  function automatic int unsigned sender_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic push_pixel(input logic [iib_pkg::PIX_W-1:0] color);
    int unsigned gap;
    bit          taken;
    gap = sender_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_color_i <= color;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    pending_sums.insert(pending_sums.size(), integrate_pixel(color));
    pixels_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_geometry_reg(input logic [iib_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [iib_pkg::CFG_W-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    if (idx == iib_pkg::REG_IMAGE_WIDTH) width_reg = value;
    else if (idx == iib_pkg::REG_IMAGE_HEIGHT) height_reg = value;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // color extremes at the reset geometry, no idling
  task automatic test_directed_colors();
    logic [iib_pkg::PIX_W-1:0] colors [20];
    colors = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
               24'h00FFFF, 24'hFF00FF, 24'hFFFF00, 24'h010101, 24'h808080,
               24'h7F7F7F, 24'h1F1F1F, 24'h000001, 24'h800000, 24'h008000,
               24'h000080, 24'hFEFEFE, 24'h555555, 24'hAAAAAA, 24'hFFFFFF};
    quiet = 1'b1;
    foreach (colors[i]) push_pixel(colors[i]);
    quiet = 1'b0;
  endtask

  // finish the 320-wide first row and step into the second one
  task automatic test_reset_geometry();
    repeat (310) push_pixel(random_pixel());
  endtask

  // shrink the row while past its new end, cut the frame short
  task automatic test_midframe_change();
    write_geometry_reg(iib_pkg::REG_IMAGE_WIDTH, 10'd6);
    write_geometry_reg(iib_pkg::REG_IMAGE_HEIGHT, 10'd3);
    repeat (30) push_pixel(random_pixel());
  endtask

  task automatic test_zero_dims();
    write_geometry_reg(iib_pkg::REG_IMAGE_WIDTH, 10'd0);
    write_geometry_reg(iib_pkg::REG_IMAGE_HEIGHT, 10'd0);
    repeat (6) push_pixel(random_pixel());
    write_geometry_reg(iib_pkg::REG_IMAGE_HEIGHT, 10'd4);
    repeat (8) push_pixel(random_pixel());
  endtask

  // full-width first row, then a few pixels that read it back
  task automatic test_oversized_width();
    write_geometry_reg(iib_pkg::REG_IMAGE_HEIGHT, 10'd0);
    while (row_at != 0 || col_at != 0) push_pixel(random_pixel());
    write_geometry_reg(iib_pkg::REG_IMAGE_WIDTH, 10'd600);
    write_geometry_reg(iib_pkg::REG_IMAGE_HEIGHT, 10'd1023);
    repeat (iib_pkg::MAX_WIDTH + 16) push_pixel(random_pixel());
  endtask

  task automatic test_oversized_height();
    write_geometry_reg(iib_pkg::REG_IMAGE_WIDTH, 10'd1);
    repeat (iib_pkg::MAX_HEIGHT + 8) push_pixel(random_pixel());
  endtask

  task automatic test_random_frames();
    logic [iib_pkg::CFG_W-1:0] w;
    logic [iib_pkg::CFG_W-1:0] h;
    int unsigned               burst;
    while (pixels_sent < RANDOM_TARGET) begin
      quiet = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        8:       w = '0;
        9:       w = iib_pkg::CFG_W'($urandom);
        default: w = iib_pkg::CFG_W'($urandom_range(1, 24));
      endcase
      case ($urandom_range(0, 9))
        8:       h = '0;
        9:       h = iib_pkg::CFG_W'($urandom);
        default: h = iib_pkg::CFG_W'($urandom_range(1, 6));
      endcase
      if ($urandom_range(0, 2) != 0 && width_ok(w)) begin
        write_geometry_reg(iib_pkg::REG_IMAGE_WIDTH, w);
      end
      if ($urandom_range(0, 2) != 0) write_geometry_reg(iib_pkg::REG_IMAGE_HEIGHT, h);
      if ($urandom_range(0, 9) == 0) begin
        write_geometry_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                           iib_pkg::CFG_W'($urandom));
      end
      burst = $urandom_range(10, 70);
      repeat (burst) push_pixel(random_pixel());
    end
    quiet = 1'b0;
  endtask

  initial begin : stall_driver
    int unsigned hold;
    int unsigned r;
    hold = 0;
    forever begin
      @(posedge clk_i);
      r = $urandom_range(0, 99);
      if (hold != 0) hold--;
      else if (!quiet && r < 20) hold = $urandom_range(1, 3);
      else if (!quiet && r < 23) hold = $urandom_range(8, 40);
      out_stall_i <= (hold != 0);
    end
  end

  // result taken at the next rising edge; sampled at the falling edge before it
  initial begin : result_checker
    iib_pkg::result_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_sums.size() == 0) begin
          report_mismatch("result with no request pending", area_sum_o, 0);
        end else begin
          want = pending_sums.pop_front();
          if (area_sum_o !== want.area)
            report_mismatch("area_sum", area_sum_o, want.area);
          if (row_end_o !== want.row_end)
            report_mismatch("row_end", row_end_o, want.row_end);
          if (frame_end_o !== want.frame_end)
            report_mismatch("frame_end", frame_end_o, want.frame_end);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : sequencer
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_colors();
    test_reset_geometry();
    test_midframe_change();
    test_zero_dims();
    test_oversized_width();
    test_oversized_height();
    test_random_frames();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
